### rtl/lbs_pkg.sv
// Shared widths, codes and handshake structs for the LED blink sequencer.
`default_nettype none

package lbs_pkg;

    // Field widths
    localparam int LED_W      = 8;
    localparam int DUTY_W     = 7;
    localparam int PERIOD_W   = 16;
    localparam int EV_W       = 3;
    localparam int MODE_W     = 2;
    localparam int CNT_W      = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int IN_DATA_W  = 32;

    // Request kinds carried in tuser
    localparam logic REQ_SET  = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    // Event codes
    localparam logic [EV_W-1:0] EV_STOP       = 3'd0;
    localparam logic [EV_W-1:0] EV_BLINK_ONCE = 3'd1;
    localparam logic [EV_W-1:0] EV_FLASH      = 3'd2;
    localparam logic [EV_W-1:0] EV_QUARTER    = 3'd3;
    localparam logic [EV_W-1:0] EV_HALF       = 3'd4;

    // Stop modes
    localparam logic [MODE_W-1:0] MODE_NONE   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ON     = 2'd1;
    localparam logic [MODE_W-1:0] MODE_OFF    = 2'd2;
    localparam logic [MODE_W-1:0] MODE_TOGGLE = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BLINK_DUTY   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_QUARTER_DUTY = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_DUTY    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FLASH_PERIOD = 2'd3;

    // Reset values
    localparam logic [DUTY_W-1:0]   RST_BLINK_DUTY   = 7'd5;
    localparam logic [DUTY_W-1:0]   RST_QUARTER_DUTY = 7'd25;
    localparam logic [DUTY_W-1:0]   RST_HALF_DUTY    = 7'd50;
    localparam logic [PERIOD_W-1:0] RST_FLASH_PERIOD = 16'd1000;

    localparam logic [CNT_W-1:0]  ENDLESS_COUNT = 8'd255;
    localparam logic [CNT_W-1:0]  ONCE_COUNT    = 8'd1;
    localparam logic [DUTY_W-1:0] DUTY_MAX      = 7'd100;

    // Interval = pct * period / 100 by reciprocal multiply plus one correction.
    // 41943 / 2^22 sits just below 1/100, so the estimate is low by at most one.
    localparam int PROD_W      = DUTY_W + PERIOD_W;
    localparam int RECIP_W     = 16;
    localparam int MUL_W       = PROD_W + RECIP_W;
    localparam int RECIP_SHIFT = 22;
    localparam int Q_W         = MUL_W - RECIP_SHIFT;
    localparam logic [RECIP_W-1:0] RECIP_MUL = 16'd41943;
    localparam logic [PROD_W-1:0]  DIVISOR   = 23'd100;

    typedef struct packed {
        logic load_item;
        logic scan_step;
        logic out_load;
    } lbs_cmd_t;

    typedef struct packed {
        logic scan_last;
        logic pipe_busy;
    } lbs_status_t;

endpackage

`default_nettype wire

### rtl/led_blink_sequencer_core.sv
// Top level of the LED blink sequencer: stream ports, controller and datapath.
// Flow: IDLE registers the input beat, SCAN walks one LED per cycle, DRAIN waits out the
// divide pipeline and DONE loads the output register behind m_axis_tvalid.
// No beat is taken until the current item is done; a held result beat stalls the next item.
// Reset (rst_n low, async): LEDs off and stopped, config at 5/25/50 percent, 1000-tick period.
`default_nettype none

module led_blink_sequencer_core #(
    parameter int NUM_LEDS = 8
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    // input beat
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    // [7:0] led_mask, [10:8] event_code, [12:11] stop_mode,
    // [28:13] elapsed_ticks, [31:29] zero
    input  wire logic [lbs_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // [0] req_type
    input  wire logic                               s_axis_tuser,
    // result beat
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    // [7:0] led_state
    output logic [lbs_pkg::LED_W-1:0]               m_axis_tdata,
    // configuration writes
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [lbs_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [lbs_pkg::CFG_DATA_W-1:0]     cfg_data
);

    lbs_pkg::lbs_cmd_t    cmd;
    lbs_pkg::lbs_status_t status;

    // Config writes are always accepted; they must arrive only while the block idles, which it does not enforce.
    assign cfg_ready = 1'b1;

    // Controller: take a beat, walk every LED once, wait out the divide
    // pipeline, then drop the LED vector into the output register.
    lbs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .cmd       (cmd),
        .status    (status)
    );

    // Datapath: unpack the beat fields, hold per-LED blink state and run the
    // shared duty-times-period-over-100 unit.
    lbs_dp #(
        .NUM_LEDS (NUM_LEDS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .in_req     (s_axis_tuser),
        .in_mask    (s_axis_tdata[7:0]),
        .in_event   (s_axis_tdata[10:8]),
        .in_mode    (s_axis_tdata[12:11]),
        .in_elapsed (s_axis_tdata[28:13]),
        .cfg_we     (cfg_valid),
        .cfg_idx    (cfg_index),
        .cfg_wdata  (cfg_data),
        .led_out    (m_axis_tdata)
    );

endmodule

`default_nettype wire

### rtl/lbs_ctrl.sv
// Sequencer controller: accepts a beat, walks the LEDs, drains, issues the result.
`default_nettype none

module lbs_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output lbs_pkg::lbs_cmd_t       cmd,
    input  wire lbs_pkg::lbs_status_t status
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DONE
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next    = state_reg;
        cmd           = '0;
        in_ready      = (state_reg == ST_IDLE);
        out_valid_next = out_valid_reg & ~out_ready;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (status.scan_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!status.pipe_busy)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                // hold until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("second beat taken while an item is in flight");

    a_done_drained: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE) |-> !status.pipe_busy)
        else $error("result issued before interval pipeline drained");

endmodule

`default_nettype wire

### rtl/lbs_dp.sv
// Sequencer datapath: per-LED state, config registers, interval pipeline.
`default_nettype none

module lbs_dp #(
    parameter int NUM_LEDS = 8
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire lbs_pkg::lbs_cmd_t                   cmd,
    output lbs_pkg::lbs_status_t                     status,
    input  wire logic                                in_req,
    input  wire logic [lbs_pkg::LED_W-1:0]           in_mask,
    input  wire logic [lbs_pkg::EV_W-1:0]            in_event,
    input  wire logic [lbs_pkg::MODE_W-1:0]          in_mode,
    input  wire logic [lbs_pkg::PERIOD_W-1:0]        in_elapsed,
    input  wire logic                                cfg_we,
    input  wire logic [lbs_pkg::CFG_IDX_W-1:0]       cfg_idx,
    input  wire logic [lbs_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    output logic [lbs_pkg::LED_W-1:0]                led_out
);

    localparam int IDX_W = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_LEDS - 1);

    // Item registers
    logic                           req_reg;
    logic [lbs_pkg::LED_W-1:0]      mask_reg;
    logic [lbs_pkg::EV_W-1:0]       ev_reg;
    logic [lbs_pkg::MODE_W-1:0]     mode_reg;
    logic [lbs_pkg::PERIOD_W-1:0]   elapsed_reg;

    // Configuration registers
    logic [lbs_pkg::DUTY_W-1:0]     blink_duty_reg;
    logic [lbs_pkg::DUTY_W-1:0]     quarter_duty_reg;
    logic [lbs_pkg::DUTY_W-1:0]     half_duty_reg;
    logic [lbs_pkg::PERIOD_W-1:0]   flash_period_reg;

    // Per-LED state
    logic [lbs_pkg::EV_W-1:0]       event_reg  [NUM_LEDS];
    logic [lbs_pkg::CNT_W-1:0]      count_reg  [NUM_LEDS];
    logic [lbs_pkg::DUTY_W-1:0]     pct_reg    [NUM_LEDS];
    logic [lbs_pkg::PERIOD_W-1:0]   period_reg [NUM_LEDS];
    logic [lbs_pkg::PERIOD_W-1:0]   ttn_reg    [NUM_LEDS];
    logic [NUM_LEDS-1:0]            lit_reg;

    logic [IDX_W-1:0]               idx_reg;
    logic [lbs_pkg::LED_W-1:0]      led_out_reg;

    // Interval pipeline
    logic                           s1_valid_reg, s2_valid_reg;
    logic [IDX_W-1:0]               s1_idx_reg, s2_idx_reg;
    logic [lbs_pkg::PROD_W-1:0]     s1_prod_reg, s2_prod_reg;
    logic [lbs_pkg::Q_W-1:0]        s2_q0_reg;

    // Decision for the LED under the scan index
    logic [lbs_pkg::EV_W-1:0]       cur_ev, dec_ev;
    logic [lbs_pkg::CNT_W-1:0]      cur_cnt, dec_cnt;
    logic [lbs_pkg::DUTY_W-1:0]     cur_pct, dec_pct;
    logic [lbs_pkg::PERIOD_W-1:0]   cur_period, dec_period;
    logic [lbs_pkg::PERIOD_W-1:0]   cur_ttn, dec_ttn;
    logic                           cur_lit, dec_lit;
    logic                           dec_ttn_we;
    logic                           issue;
    logic [lbs_pkg::DUTY_W-1:0]     issue_pct;
    logic [lbs_pkg::DUTY_W-1:0]     load_duty;
    logic [lbs_pkg::PROD_W-1:0]     dec_prod;

    logic [lbs_pkg::MUL_W-1:0]      recip_prod;
    logic [lbs_pkg::PROD_W-1:0]     q0_x100;
    logic [lbs_pkg::PROD_W-1:0]     rem_raw;
    logic [lbs_pkg::PROD_W-1:0]     rem_fixed;
    logic                           rem_over;
    logic [lbs_pkg::PERIOD_W-1:0]   interval;
    logic [lbs_pkg::LED_W-1:0]      lit_ext;

    always_comb
    begin
        cur_ev     = event_reg[idx_reg];
        cur_cnt    = count_reg[idx_reg];
        cur_pct    = pct_reg[idx_reg];
        cur_period = period_reg[idx_reg];
        cur_ttn    = ttn_reg[idx_reg];
        cur_lit    = lit_reg[idx_reg];

        dec_ev     = cur_ev;
        dec_cnt    = cur_cnt;
        dec_pct    = cur_pct;
        dec_period = cur_period;
        dec_ttn    = cur_ttn;
        dec_lit    = cur_lit;
        dec_ttn_we = 1'b0;
        issue      = 1'b0;
        issue_pct  = cur_pct;

        priority if (ev_reg == lbs_pkg::EV_QUARTER)
            load_duty = quarter_duty_reg;
        else if (ev_reg == lbs_pkg::EV_HALF)
            load_duty = half_duty_reg;
        else
            load_duty = blink_duty_reg;
        if (load_duty > lbs_pkg::DUTY_MAX)
        begin
            load_duty = lbs_pkg::DUTY_MAX;
        end

        if (req_reg == lbs_pkg::REQ_SET)
        begin
            // codes above half flash leave the LED alone
            if (mask_reg[idx_reg] && ev_reg <= lbs_pkg::EV_HALF)
            begin
                if (ev_reg == lbs_pkg::EV_STOP)
                begin
                    unique case (mode_reg)
                        lbs_pkg::MODE_NONE:   dec_lit = cur_lit;
                        lbs_pkg::MODE_ON:     dec_lit = 1'b1;
                        lbs_pkg::MODE_OFF:    dec_lit = 1'b0;
                        lbs_pkg::MODE_TOGGLE: dec_lit = ~cur_lit;
                    endcase
                    dec_ev = lbs_pkg::EV_STOP;
                end
                else if (ev_reg != cur_ev)
                begin
                    dec_ev     = ev_reg;
                    dec_pct    = load_duty;
                    dec_cnt    = (ev_reg == lbs_pkg::EV_BLINK_ONCE) ?
                                 lbs_pkg::ONCE_COUNT : lbs_pkg::ENDLESS_COUNT;
                    dec_period = flash_period_reg;
                    dec_ttn    = '0;
                    dec_ttn_we = 1'b1;
                    dec_lit    = 1'b0;
                end
            end
        end
        else if (cur_ev != lbs_pkg::EV_STOP)
        begin
            if (elapsed_reg < cur_ttn)
            begin
                dec_ttn    = cur_ttn - elapsed_reg;
                dec_ttn_we = 1'b1;
            end
            else
            begin
                if (cur_lit)
                begin
                    issue_pct = lbs_pkg::DUTY_MAX - cur_pct;
                    dec_lit   = 1'b0;
                    if (cur_cnt != lbs_pkg::ENDLESS_COUNT)
                    begin
                        dec_cnt = cur_cnt - 1'b1;
                    end
                end
                else
                begin
                    issue_pct = cur_pct;
                    dec_lit   = 1'b1;
                end
                if (dec_cnt == '0)
                begin
                    dec_ev = lbs_pkg::EV_STOP;
                end
                issue = 1'b1;
            end
        end

        dec_prod = lbs_pkg::PROD_W'(issue_pct) * lbs_pkg::PROD_W'(cur_period);
    end

    // Quotient estimate and one-step correction
    assign recip_prod = lbs_pkg::MUL_W'(s1_prod_reg) * lbs_pkg::MUL_W'(lbs_pkg::RECIP_MUL);
    assign q0_x100    = lbs_pkg::PROD_W'(s2_q0_reg) * lbs_pkg::DIVISOR;
    assign rem_raw    = s2_prod_reg - q0_x100;
    assign rem_over   = (rem_raw >= lbs_pkg::DIVISOR);
    assign rem_fixed  = rem_over ? (rem_raw - lbs_pkg::DIVISOR) : rem_raw;
    assign interval   = lbs_pkg::PERIOD_W'(s2_q0_reg + lbs_pkg::Q_W'(rem_over));

    always_comb
    begin
        lit_ext                = '0;
        lit_ext[NUM_LEDS-1:0]  = lit_reg;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            req_reg     <= in_req;
            mask_reg    <= in_mask;
            ev_reg      <= in_event;
            mode_reg    <= in_mode;
            elapsed_reg <= in_elapsed;
        end
        s1_idx_reg  <= idx_reg;
        s1_prod_reg <= dec_prod;
        s2_idx_reg  <= s1_idx_reg;
        s2_prod_reg <= s1_prod_reg;
        s2_q0_reg   <= recip_prod[lbs_pkg::RECIP_SHIFT +: lbs_pkg::Q_W];
        if (cmd.out_load)
        begin
            led_out_reg <= lit_ext;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blink_duty_reg   <= lbs_pkg::RST_BLINK_DUTY;
            quarter_duty_reg <= lbs_pkg::RST_QUARTER_DUTY;
            half_duty_reg    <= lbs_pkg::RST_HALF_DUTY;
            flash_period_reg <= lbs_pkg::RST_FLASH_PERIOD;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx)
                lbs_pkg::CFG_BLINK_DUTY:   blink_duty_reg   <= cfg_wdata[lbs_pkg::DUTY_W-1:0];
                lbs_pkg::CFG_QUARTER_DUTY: quarter_duty_reg <= cfg_wdata[lbs_pkg::DUTY_W-1:0];
                lbs_pkg::CFG_HALF_DUTY:    half_duty_reg    <= cfg_wdata[lbs_pkg::DUTY_W-1:0];
                lbs_pkg::CFG_FLASH_PERIOD: flash_period_reg <= cfg_wdata;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_LEDS; i++)
            begin
                event_reg[i]  <= lbs_pkg::EV_STOP;
                count_reg[i]  <= '0;
                pct_reg[i]    <= '0;
                period_reg[i] <= lbs_pkg::RST_FLASH_PERIOD;
                ttn_reg[i]    <= '0;
            end
            lit_reg      <= '0;
            idx_reg      <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= cmd.scan_step & issue;
            s2_valid_reg <= s1_valid_reg;
            if (cmd.load_item)
            begin
                idx_reg <= '0;
            end
            else if (cmd.scan_step)
            begin
                idx_reg <= (idx_reg == LAST_IDX) ? '0 : idx_reg + 1'b1;
            end
            if (cmd.scan_step)
            begin
                event_reg[idx_reg]  <= dec_ev;
                count_reg[idx_reg]  <= dec_cnt;
                pct_reg[idx_reg]    <= dec_pct;
                period_reg[idx_reg] <= dec_period;
                lit_reg[idx_reg]    <= dec_lit;
                if (dec_ttn_we)
                begin
                    ttn_reg[idx_reg] <= dec_ttn;
                end
            end
            // retire an interval from stage two, at the index it was issued for
            if (s2_valid_reg)
            begin
                ttn_reg[s2_idx_reg] <= interval;
            end
        end
    end

    assign status.scan_last = (idx_reg == LAST_IDX);
    assign status.pipe_busy = s1_valid_reg | s2_valid_reg;
    assign led_out          = led_out_reg;

    a_pipe_order: assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg |-> $past(s1_valid_reg))
        else $error("interval stage two valid without stage one");

    a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg |-> (rem_fixed < lbs_pkg::DIVISOR))
        else $error("reciprocal estimate off by more than one");

endmodule

`default_nettype wire
